// ----- rtl/lbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

   // Fixed field and register widths.
   localparam int CFG_BITS       = 12;
   localparam int ROW_BITS       = 11;
   localparam int CODE_BITS      = 8;
   localparam int HEIGHT_MAX     = 2048;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;

   // Register values after reset.
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

   // Result queue between the window stage and the output port.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Register index, taken from the word address.
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Control of the word held between the front and the window stage.
   typedef struct packed {
      logic valid;
      logic has_code;
      logic frame_last;
   } stage_ctrl_type;

   // One entry of the result queue.
   typedef struct packed {
      logic [CODE_BITS-1:0] pattern_code;
      logic                 frame_last;
   } code_word_type;

endpackage

`default_nettype wire

// ----- rtl/lbp_pixel_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pixel stream channel.
interface lbp_pixel_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  frame_start;

   modport source(output valid, output pixel, output frame_start, input ready);
   modport sink(input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/lbp_code_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pattern code channel.
interface lbp_code_if;
   import lbp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] pattern_code;
   logic                 frame_last;

   modport source(output valid, output pattern_code, output frame_last, input ready);
   modport sink(input valid, input pattern_code, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/lbp_3x3_pixel_stream_unit.sv -----
// 3x3 local binary pattern over a raster pixel stream.
//
// req_bus carries one pixel per word in raster order; frame_start marks row 0,
// column 0 of a frame and restarts the position counters. rsp_bus carries one
// 8-bit pattern code for each interior pixel, (height-2) by (width-2) codes per
// frame, with frame_last set on the last code of a frame. The code of a pixel
// leaves with the word that delivers its bottom-right neighbor.
// The csr port holds frame_width at address 0 and frame_height at address 4;
// change them only while the block is idle.
//
// Throughput is one pixel per cycle while req ready is high; the line store is
// read and written once per pixel. A code is computed from the stage register and
// written into the result queue before it is valid on rsp_bus. A four-entry queue
// sits before the output, so req_bus keeps taking pixels while a code waits; when
// the receiver stalls and the queue fills, req ready drops until space opens.
// Reset clears the counters, the window and the queue and loads width 640 and
// height 480; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lbp_3x3_pixel_stream_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   lbp_pixel_if.sink                           req_bus,
   lbp_code_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lbp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lbp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lbp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import lbp_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic [CFG_BITS-1:0]       width_ff, width_in;
   logic [CFG_BITS-1:0]       height_ff, height_in;
   csr_index_type             csr_index;
   logic                      csr_write;
   logic [QUEUE_CNT_BITS-1:0] queue_count;
   logic                      rd_en;
   logic [COL_BITS-1:0]       rd_addr;
   logic [2*PIXEL_BITS-1:0]   rd_data;
   logic                      wr_en;
   logic [2*PIXEL_BITS-1:0]   wr_data;
   stage_ctrl_type            s1_ctrl;
   logic [PIXEL_BITS-1:0]     s1_pixel;
   logic [COL_BITS-1:0]       s1_addr;
   logic                      push;
   code_word_type             push_word;

   // Configuration registers.
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_pwdata[CFG_BITS-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_pwdata[CFG_BITS-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         CSR_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Front: position counters, classification and line store read.
   lbp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .queue_count  (queue_count),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .s1_ctrl      (s1_ctrl),
      .s1_pixel     (s1_pixel),
      .s1_addr      (s1_addr)
   );

   // Two previous rows, one entry per column.
   lbp_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * PIXEL_BITS)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_data)
   );

   // Back: window and comparisons.
   lbp_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .s1_ctrl   (s1_ctrl),
      .s1_pixel  (s1_pixel),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_data   (wr_data),
      .push      (push),
      .push_word (push_word)
   );

   // Result queue and output channel.
   lbp_code_queue u_code_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_word   (push_word),
      .queue_count (queue_count),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- rtl/lbp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8,
   localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lbp_pixel_if.sink                            req_bus,
   input  logic [lbp_pkg::CFG_BITS-1:0]         frame_width,
   input  logic [lbp_pkg::CFG_BITS-1:0]         frame_height,
   input  logic [lbp_pkg::QUEUE_CNT_BITS-1:0]   queue_count,
   output logic                                 rd_en,
   output logic [COL_BITS-1:0]                  rd_addr,
   output lbp_pkg::stage_ctrl_type              s1_ctrl,
   output logic [PIXEL_BITS-1:0]                s1_pixel,
   output logic [COL_BITS-1:0]                  s1_addr
);
   import lbp_pkg::*;

   localparam int WCMP_BITS = (CFG_BITS > COL_BITS + 1) ? CFG_BITS : COL_BITS + 1;
   localparam int OCC_BITS  = QUEUE_CNT_BITS + 1;

   logic [WCMP_BITS-1:0] width_ext;
   logic [COL_BITS-1:0]  col_last;
   logic [ROW_BITS-1:0]  row_last;
   logic [COL_BITS-1:0]  col_ff, col_in, col_cur;
   logic [ROW_BITS-1:0]  row_ff, row_in, row_cur;
   logic                 accept;
   logic                 has_code;
   logic                 is_last;
   logic [OCC_BITS-1:0]  occupancy;
   stage_ctrl_type       ctrl_ff, ctrl_in;
   logic [PIXEL_BITS-1:0] pixel_ff;
   logic [COL_BITS-1:0]  addr_ff;

   // Last column and last row in use, with the registers saturated to their legal range.
   assign width_ext = WCMP_BITS'(frame_width);

   always_comb begin
      if (frame_width < CFG_BITS'(3)) begin
         col_last = COL_BITS'(2);
      end else if (width_ext > WCMP_BITS'(MAX_WIDTH)) begin
         col_last = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_BITS'(width_ext - WCMP_BITS'(1));
      end
   end

   always_comb begin
      if (frame_height < CFG_BITS'(3)) begin
         row_last = ROW_BITS'(2);
      end else if (frame_height > CFG_BITS'(HEIGHT_MAX)) begin
         row_last = ROW_BITS'(HEIGHT_MAX - 1);
      end else begin
         row_last = ROW_BITS'(frame_height - CFG_BITS'(1));
      end
   end

   // Accept only when the result queue has room for every word still in flight.
   assign occupancy = OCC_BITS'(queue_count) + OCC_BITS'(ctrl_ff.valid && ctrl_ff.has_code);
   assign req_bus.ready = occupancy < OCC_BITS'(QUEUE_DEPTH);
   assign accept = req_bus.valid && req_bus.ready;

   // Position of this pixel; a frame start restarts the raster at once.
   assign col_cur = req_bus.frame_start ? '0 : col_ff;
   assign row_cur = req_bus.frame_start ? '0 : row_ff;

   // Classify: interior pixels give a code, the last one of the frame is flagged.
   assign has_code = (row_cur >= ROW_BITS'(2)) && (col_cur >= COL_BITS'(2));
   assign is_last  = (row_cur >= row_last) && (col_cur >= col_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur >= col_last) begin
            col_in = '0;
            row_in = (row_cur >= row_last) ? '0 : row_cur + ROW_BITS'(1);
         end else begin
            col_in = col_cur + COL_BITS'(1);
            row_in = row_cur;
         end
      end
   end

   always_comb begin
      ctrl_in.valid      = accept;
      ctrl_in.has_code   = has_code;
      ctrl_in.frame_last = is_last;
   end

   // Counters and stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ctrl_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ctrl_ff <= ctrl_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= req_bus.pixel;
         addr_ff  <= col_cur;
      end
   end

   // The line store is read for the accepted column in the same cycle.
   assign rd_en    = accept;
   assign rd_addr  = col_cur;
   assign s1_ctrl  = ctrl_ff;
   assign s1_pixel = pixel_ff;
   assign s1_addr  = addr_ff;

endmodule

`default_nettype wire

// ----- rtl/lbp_line_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_line_store #(
   parameter int DEPTH      = 2048,
   parameter int DATA_BITS  = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);
   // Each entry holds the two previous rows of one column: upper in the high half.
   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Registered read; a write to the same column in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= store_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lbp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_back #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lbp_pkg::stage_ctrl_type   s1_ctrl,
   input  logic [PIXEL_BITS-1:0]     s1_pixel,
   input  logic [2*PIXEL_BITS-1:0]   rd_data,
   output logic                      wr_en,
   output logic [2*PIXEL_BITS-1:0]   wr_data,
   output logic                      push,
   output lbp_pkg::code_word_type    push_word
);
   import lbp_pkg::*;

   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [PIXEL_BITS-1:0] top_right;
   logic [PIXEL_BITS-1:0] mid_right;
   logic [PIXEL_BITS-1:0] centre;

   // Right column of the window comes from the line store and the new pixel.
   assign top_right = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid_right = rd_data[PIXEL_BITS-1:0];
   assign centre    = win_ff[4];

   // Shift the window one column left for every word.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_ctrl.valid) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_right;
         win_ff[4] <= mid_right;
         win_ff[5] <= s1_pixel;
      end
   end

   // Rows move up by one in the line store.
   assign wr_en   = s1_ctrl.valid;
   assign wr_data = {mid_right, s1_pixel};

   // Eight comparisons, clockwise from the top-left neighbor.
   always_comb begin
      push_word.pattern_code[7] = win_ff[0] > centre;
      push_word.pattern_code[6] = win_ff[3] > centre;
      push_word.pattern_code[5] = top_right > centre;
      push_word.pattern_code[4] = mid_right > centre;
      push_word.pattern_code[3] = s1_pixel > centre;
      push_word.pattern_code[2] = win_ff[5] > centre;
      push_word.pattern_code[1] = win_ff[2] > centre;
      push_word.pattern_code[0] = win_ff[1] > centre;
      push_word.frame_last      = s1_ctrl.frame_last;
   end

   assign push = s1_ctrl.valid && s1_ctrl.has_code;

endmodule

`default_nettype wire

// ----- rtl/lbp_code_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_code_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  lbp_pkg::code_word_type              push_word,
   output logic [lbp_pkg::QUEUE_CNT_BITS-1:0]  queue_count,
   lbp_code_if.source                          rsp_bus
);
   import lbp_pkg::*;

   code_word_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                       pop;

   assign pop = rsp_bus.valid && rsp_bus.ready;

   // Pointer and fill count update; the front never pushes into a full queue.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   // The head entry drives the output channel.
   assign rsp_bus.valid        = count_ff != '0;
   assign rsp_bus.pattern_code = entry_ff[rd_ptr_ff].pattern_code;
   assign rsp_bus.frame_last   = entry_ff[rd_ptr_ff].frame_last;
   assign queue_count          = count_ff;

endmodule

`default_nettype wire

// ----- rtl/lbp_port_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_port_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [lbp_pkg::CODE_BITS-1:0]   rsp_pattern_code,
   input  logic                            rsp_frame_last,
   input  logic                            csr_pready
);
   // A stalled code holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pattern_code) && $stable(rsp_frame_last))
      else $error("stalled code changed or was withdrawn");

   // An empty output only fills from a pixel that was taken and then held in the stage register.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("code appeared without a matching pixel");

   // No code is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("code offered right after reset");

   // The register port never inserts wait states.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind lbp_3x3_pixel_stream_unit lbp_port_checker u_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_pattern_code (rsp_bus.pattern_code),
   .rsp_frame_last   (rsp_bus.frame_last),
   .csr_pready       (csr_pready)
);

`default_nettype wire
